### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SITDA_ASSERT_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same, on the block's own clock and reset.
`define SITDA_ASSERT(label, prop, msg) \
    `SITDA_ASSERT_ON(label, i_clk, i_rst_n, prop, msg)

`endif

### rtl/sitda_pkg.sv
package sitda_pkg;

    localparam int C_VALUE_W  = 32;
    localparam int C_DIGITS   = 10;
    localparam int C_DIGIT_W  = 4;
    localparam int C_BCD_W    = C_DIGITS * C_DIGIT_W;
    localparam int C_CHAR_W   = 6;
    localparam int C_STEP_W   = $clog2(C_VALUE_W);
    localparam int C_REM_W    = $clog2(C_DIGITS + 1);

    localparam logic [C_CHAR_W-1:0] C_ASCII_ZERO  = 6'd48;
    localparam logic [C_CHAR_W-1:0] C_ASCII_MINUS = 6'd45;

    // Converted magnitude and sign handed from the converter to the emitter
    typedef struct packed {
        logic                 neg;
        logic [C_BCD_W-1:0]   bcd;
    } t_conv;

endpackage

### rtl/sitda_intf.sv
interface sitda_in_if;
    import sitda_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [C_VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
    import sitda_pkg::*;

    logic                valid;
    logic                ready;
    logic [C_CHAR_W-1:0] character;
    logic                last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

### rtl/signed_int_to_decimal_ascii_unit.sv
// Signed 32-bit integer to decimal ASCII text. Each input item is one two's
// complement value; the output channel returns its text one character per
// item, a minus sign first for negative values, no leading zeros, and last
// set on the final digit. The magnitude is converted to BCD by a shift-and-
// add-three converter that takes one bit per cycle and then holds its result
// until the digit emitter takes it. The emitter skips up to nine leading
// zeros and then offers the characters (1 to 11 of them), holding each while
// the output is stalled. Emission overlaps the conversion of the next value,
// but the converter takes a new value only after handing the last one over.
// A leading minus sign is offered before the leading zeros are skipped, the
// first digit after them.
module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sitda_in_if.sink    i_in,
    sitda_out_if.source o_out
);

    logic  w_in_ready;
    logic  w_conv_valid;
    logic  w_conv_ready;
    t_conv w_conv;

    sitda_dabble u_dabble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_value      (i_in.value),
        .o_ready      (w_in_ready),
        .o_conv_valid (w_conv_valid),
        .i_conv_ready (w_conv_ready),
        .o_conv       (w_conv)
    );

    sitda_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_conv_valid (w_conv_valid),
        .i_conv       (w_conv),
        .o_conv_ready (w_conv_ready),
        .o_valid      (o_out.valid),
        .o_character  (o_out.character),
        .o_last       (o_out.last),
        .i_ready      (o_out.ready)
    );

    assign i_in.ready = w_in_ready;

endmodule

### rtl/sitda_dabble.sv
module sitda_dabble
    import sitda_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [C_VALUE_W-1:0] i_value,
    output logic                        o_ready,
    output logic                        o_conv_valid,
    input  logic                        i_conv_ready,
    output t_conv                       o_conv
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [C_VALUE_W-1:0]   r_bin;
    logic [C_BCD_W-1:0]     r_bcd;
    logic [C_BCD_W-1:0]     w_bcd_adj;
    logic                   r_neg;
    logic [C_STEP_W-1:0]    r_step;
    logic [C_VALUE_W-1:0]   w_raw;
    logic [C_VALUE_W-1:0]   w_mag;

    assign w_raw = C_VALUE_W'(i_value);
    assign w_mag = w_raw[C_VALUE_W-1] ? (~w_raw + C_VALUE_W'(1)) : w_raw;

    // Add three to every digit of five or more before the shift
    always_comb begin
        logic [C_DIGIT_W-1:0] d;
        for (int k = 0; k < C_DIGITS; k++) begin
            d = r_bcd[k*C_DIGIT_W +: C_DIGIT_W];
            if (d >= 4'd5) begin
                w_bcd_adj[k*C_DIGIT_W +: C_DIGIT_W] = d + 4'd3;
            end else begin
                w_bcd_adj[k*C_DIGIT_W +: C_DIGIT_W] = d;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_step == C_STEP_W'(C_VALUE_W - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_conv_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_bin  <= w_mag;
            r_neg  <= w_raw[C_VALUE_W-1];
            r_bcd  <= '0;
            r_step <= '0;
        end else if (r_state == S_SHIFT) begin
            {r_bcd, r_bin} <= {w_bcd_adj[C_BCD_W-2:0], r_bin, 1'b0};
            r_step         <= r_step + C_STEP_W'(1);
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_conv_valid = (r_state == S_DONE);
    assign o_conv.neg   = r_neg;
    assign o_conv.bcd   = r_bcd;

endmodule

### rtl/sitda_emit.sv
module sitda_emit
    import sitda_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_conv_valid,
    input  t_conv               i_conv,
    output logic                o_conv_ready,
    output logic                o_valid,
    output logic [C_CHAR_W-1:0] o_character,
    output logic                o_last,
    input  logic                i_ready
);

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_SIGN  = 4'b0010,
        E_SKIP  = 4'b0100,
        E_DIGIT = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [C_BCD_W-1:0]     r_bcd;
    logic [C_REM_W-1:0]     r_rem;
    logic                   r_valid;
    logic [C_CHAR_W-1:0]    r_char;
    logic                   r_last;
    logic                   w_free;
    logic [C_DIGIT_W-1:0]   w_top;
    logic                   w_final;

    assign w_free  = !r_valid || i_ready;
    assign w_top   = r_bcd[C_BCD_W-1 -: C_DIGIT_W];
    assign w_final = (r_rem == C_REM_W'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: begin
                if (i_conv_valid) n_state = i_conv.neg ? E_SIGN : E_SKIP;
            end
            E_SIGN: begin
                if (w_free) n_state = E_SKIP;
            end
            E_SKIP: begin
                // drop leading zeros, but keep the units digit
                if (w_top != '0 || w_final) n_state = E_DIGIT;
            end
            E_DIGIT: begin
                if (w_free && w_final) n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == E_SIGN || r_state == E_DIGIT) && w_free) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                if (i_conv_valid) begin
                    r_bcd <= i_conv.bcd;
                    r_rem <= C_REM_W'(C_DIGITS);
                end
            end
            E_SIGN: begin
                if (w_free) begin
                    r_char <= C_ASCII_MINUS;
                    r_last <= 1'b0;
                end
            end
            E_SKIP: begin
                if (w_top == '0 && !w_final) begin
                    r_bcd <= {r_bcd[C_BCD_W-C_DIGIT_W-1:0], C_DIGIT_W'(0)};
                    r_rem <= r_rem - C_REM_W'(1);
                end
            end
            E_DIGIT: begin
                if (w_free) begin
                    r_char <= C_ASCII_ZERO + C_CHAR_W'(w_top);
                    r_last <= w_final;
                    r_bcd  <= {r_bcd[C_BCD_W-C_DIGIT_W-1:0], C_DIGIT_W'(0)};
                    r_rem  <= r_rem - C_REM_W'(1);
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_conv_ready = (r_state == E_IDLE);
    assign o_valid      = r_valid;
    assign o_character  = r_char;
    assign o_last       = r_last;

endmodule

### rtl/sitda_checker.sv
`include "assert_macros.svh"

module sitda_checker
    import sitda_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [C_CHAR_W-1:0] i_out_character,
    input logic                i_out_last
);

    // an accepted item keeps the converter busy, so input closes next cycle
    `SITDA_ASSERT(a_in_busy, i_in_valid && i_in_ready |=> !i_in_ready, "input open after accept")
    `SITDA_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "output item dropped while stalled")
    `SITDA_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_character) && $stable(i_out_last), "stalled output item changed")
    `SITDA_ASSERT(a_char_legal, i_out_valid |-> i_out_character == C_ASCII_MINUS || (i_out_character >= C_ASCII_ZERO && i_out_character <= C_ASCII_ZERO + 6'd9), "character outside sign and digits")
    `SITDA_ASSERT(a_minus_not_last, i_out_valid && i_out_character == C_ASCII_MINUS |-> !i_out_last, "minus sign flagged as last")

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_character (o_out.character),
    .i_out_last      (o_out.last)
);
